### design/pidc_pkg.sv
// Shared constants and register indexes for the PID controller block.
`timescale 1ns / 1ps

package pidc_pkg;

    // Default sample width and gain fraction
    localparam int DATA_WIDTH_DEF     = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Fixed field widths
    localparam int GAIN_W  = 16;
    localparam int CAP_W   = 15;
    localparam int SUM_W   = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = {CAP_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_CAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INC_MODE     = 3'd6;

endpackage

### design/pidc_mul_stage.sv
// Registered signed multiply of one operand by a Q-format gain.
`timescale 1ns / 1ps

module pidc_mul_stage
    import pidc_pkg::*;
#(
    parameter int A_W = 17
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [GAIN_W-1:0]    gain,
    output logic signed [A_W+GAIN_W-1:0] prod
);

    localparam int PROD_W = A_W + GAIN_W;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;

    assign prod_next = PROD_W'(a) * PROD_W'(gain);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

### design/pid_controller_deadzone_clamp_core.sv
// Top level of the PID controller with integral clamp, dead band and drive clamp.
`timescale 1ns / 1ps

// One sample in, one drive value out. The block takes a new beat every clock
// cycle unless the output stalls, and passes it through its stages: the error stage (error,
// error delta and the saturating 32-bit error sum), the multiplier stage (three
// gain products in parallel), the correction stage (arithmetic shift, integral
// clamp, sum of terms, dead band) and the output register (incremental
// accumulation and drive clamp). The error sum is updated in the cycle a beat
// is accepted and the drive value in the cycle its result enters the output
// register, so samples may follow one another without gaps. Each stage holds
// only while the stage after it is full and stalled, so empty stages keep
// taking beats while a finished result waits. Write configuration only while
// no sample is in flight; writes to indexes past the list are dropped.
module pid_controller_deadzone_clamp_core
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,

    // Sample input
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata, // reference, feedback

    // Drive output
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata, // drive
    output logic                     m_tuser            // limited
);

    localparam int W       = DATA_WIDTH;
    localparam int F       = GAIN_FRAC_BITS;
    localparam int E_W     = W + 1;
    localparam int DE_W    = W + 2;
    localparam int SUMX_W  = ((E_W > SUM_W) ? E_W : SUM_W) + 1;
    localparam int P_W     = E_W + GAIN_W;
    localparam int D_W     = DE_W + GAIN_W;
    localparam int I_W     = SUM_W + GAIN_W;
    localparam int CAPS_W  = CAP_W + 1;
    localparam int CORR_W  = W + 20;
    localparam int DRV_W   = CORR_W + 1;
    localparam int DRVX_W  = (W > CAPS_W) ? W : CAPS_W;
    localparam int OUT_W   = ((W + 7) / 8) * 8;

    localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic [CAP_W-1:0]         integral_cap_reg;
    logic [CAP_W-1:0]         drive_cap_reg;
    logic [CAP_W-1:0]         dead_band_reg;
    logic                     incremental_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg           <= '0;
            gain_i_reg           <= '0;
            gain_d_reg           <= '0;
            integral_cap_reg     <= CAP_RESET;
            drive_cap_reg        <= CAP_RESET;
            dead_band_reg        <= '0;
            incremental_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P:       gain_p_reg           <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_I:       gain_i_reg           <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_D:       gain_d_reg           <= $signed(cfg_data[GAIN_W-1:0]);
                REG_INTEGRAL_CAP: integral_cap_reg     <= cfg_data[CAP_W-1:0];
                REG_DRIVE_CAP:    drive_cap_reg        <= cfg_data[CAP_W-1:0];
                REG_DEAD_BAND:    dead_band_reg        <= cfg_data[CAP_W-1:0];
                REG_INC_MODE:     incremental_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld_out;
    logic in_accept;

    assign ld_out    = !out_valid_reg || m_tready;
    assign ld3       = !s3_valid_reg || ld_out;
    assign ld2       = !s2_valid_reg || ld3;
    assign ld1       = !s1_valid_reg || ld2;
    assign s_tready  = ld1;
    assign in_accept = s_tvalid && ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (ld2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ld3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ld_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Error stage: error, delta against the previous error, saturating sum
    // ------------------------------------------------------------------
    logic signed [W-1:0]      ref_in;
    logic signed [W-1:0]      fb_in;
    logic signed [E_W-1:0]    e_in;
    logic signed [E_W-1:0]    e_prev;
    logic signed [DE_W-1:0]   de_in;
    logic signed [SUMX_W-1:0] sum_x;
    logic signed [SUM_W-1:0]  error_sum_next;

    logic signed [E_W-1:0]    error_now_reg;
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic                     first_sample_reg;

    logic signed [E_W-1:0]    s1_e_reg;
    logic signed [DE_W-1:0]   s1_de_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg;

    assign ref_in = $signed(s_tdata[W-1:0]);
    assign fb_in  = $signed(s_tdata[2*W-1:W]);
    assign e_in   = E_W'(ref_in) - E_W'(fb_in);

    // On the first sample the previous error is the current one: no D kick
    assign e_prev = first_sample_reg ? e_in : error_now_reg;
    assign de_in  = DE_W'(e_in) - DE_W'(e_prev);

    assign sum_x  = SUMX_W'(error_sum_reg) + SUMX_W'(e_in);

    always_comb
    begin
        if (sum_x > SUMX_W'(SUM_HI))
        begin
            error_sum_next = SUM_HI;
        end
        else if (sum_x < SUMX_W'(SUM_LO))
        begin
            error_sum_next = SUM_LO;
        end
        else
        begin
            error_sum_next = sum_x[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_now_reg    <= '0;
            error_sum_reg    <= '0;
            first_sample_reg <= 1'b1;
        end
        else if (in_accept)
        begin
            error_now_reg    <= e_in;
            error_sum_reg    <= error_sum_next;
            first_sample_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_e_reg   <= e_in;
            s1_de_reg  <= de_in;
            s1_sum_reg <= error_sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Multiplier stage: three gain products
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] p_prod;
    logic signed [I_W-1:0] i_prod;
    logic signed [D_W-1:0] d_prod;

    pidc_mul_stage #(.A_W(E_W)) u_mul_p
    (
        .clk  (clk),
        .en   (ld2),
        .a    (s1_e_reg),
        .gain (gain_p_reg),
        .prod (p_prod)
    );

    pidc_mul_stage #(.A_W(SUM_W)) u_mul_i
    (
        .clk  (clk),
        .en   (ld2),
        .a    (s1_sum_reg),
        .gain (gain_i_reg),
        .prod (i_prod)
    );

    pidc_mul_stage #(.A_W(DE_W)) u_mul_d
    (
        .clk  (clk),
        .en   (ld2),
        .a    (s1_de_reg),
        .gain (gain_d_reg),
        .prod (d_prod)
    );

    // ------------------------------------------------------------------
    // Correction stage: shift (floor), clamp I, add terms, dead band
    // ------------------------------------------------------------------
    logic signed [P_W-1:0]    p_sh;
    logic signed [I_W-1:0]    i_sh;
    logic signed [D_W-1:0]    d_sh;
    logic signed [I_W-1:0]    i_cap;
    logic signed [CAPS_W-1:0] i_cl;
    logic signed [CORR_W-1:0] corr_sum;
    logic signed [CORR_W-1:0] band;
    logic signed [CORR_W-1:0] corr_next;
    logic signed [CORR_W-1:0] s3_corr_reg;

    assign p_sh  = p_prod >>> F;
    assign i_sh  = i_prod >>> F;
    assign d_sh  = d_prod >>> F;
    assign i_cap = I_W'($signed({1'b0, integral_cap_reg}));

    always_comb
    begin
        if (i_sh > i_cap)
        begin
            i_cl = $signed({1'b0, integral_cap_reg});
        end
        else if (i_sh < -i_cap)
        begin
            i_cl = -$signed({1'b0, integral_cap_reg});
        end
        else
        begin
            i_cl = i_sh[CAPS_W-1:0];
        end
    end

    assign corr_sum = CORR_W'(p_sh) + CORR_W'(i_cl) + CORR_W'(d_sh);
    assign band     = CORR_W'($signed({1'b0, dead_band_reg}));

    // Zero a correction strictly inside the band; a zero band passes all
    assign corr_next = (corr_sum < band && corr_sum > -band) ? '0 : corr_sum;

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_corr_reg <= corr_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: accumulate in incremental mode, clamp the drive
    // ------------------------------------------------------------------
    logic signed [CAPS_W-1:0] drive_value_reg;
    logic signed [DRV_W-1:0]  drv_sum;
    logic signed [DRV_W-1:0]  drv_cap;
    logic signed [CAPS_W-1:0] drv_cl;
    logic                     drv_lim;
    logic signed [DRVX_W-1:0] drv_x;
    logic [W-1:0]             out_drive_reg;
    logic                     out_limited_reg;

    assign drv_sum = incremental_mode_reg ?
                     DRV_W'(drive_value_reg) + DRV_W'(s3_corr_reg) :
                     DRV_W'(s3_corr_reg);
    assign drv_cap = DRV_W'($signed({1'b0, drive_cap_reg}));

    always_comb
    begin
        if (drv_sum > drv_cap)
        begin
            drv_cl  = $signed({1'b0, drive_cap_reg});
            drv_lim = 1'b1;
        end
        else if (drv_sum < -drv_cap)
        begin
            drv_cl  = -$signed({1'b0, drive_cap_reg});
            drv_lim = 1'b1;
        end
        else
        begin
            drv_cl  = drv_sum[CAPS_W-1:0];
            drv_lim = 1'b0;
        end
    end

    assign drv_x = DRVX_W'(drv_cl);

    // Advance the drive state only when a real beat enters the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_value_reg <= '0;
        end
        else if (ld_out && s3_valid_reg)
        begin
            drive_value_reg <= drv_cl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            out_drive_reg   <= drv_x[W-1:0];
            out_limited_reg <= drv_lim;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_drive_reg);
    assign m_tuser  = out_limited_reg;

`ifndef SYNTHESIS
    // Input stalls only when every stage holds a beat
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg))
        else $error("input stalled with an empty pipeline stage");

    // The first-sample flag drops only on an accepted beat
    a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_sample_reg) |-> $past(in_accept))
        else $error("first-sample flag cleared without an accepted beat");

    // A non-negative error never lowers the sum (saturate, never wrap)
    a_sum_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !e_in[E_W-1]) |=> (error_sum_reg >= $past(error_sum_reg)))
        else $error("error sum wrapped on a non-negative error");

    // A result appears only after the correction stage held a beat
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_valid_reg))
        else $error("output valid without a beat in the correction stage");
`endif

endmodule
